@@ rtl/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

    // Number formats of the ports.
    localparam int HUE_FRAC_BITS  = 6;
    localparam int UNIT_FRAC_BITS = 12;
    localparam int HUE_W          = 16;
    localparam int UNIT_W         = 13;
    localparam int CHAN_W         = 8;

    localparam longint UNIT_ONE    = longint'(1) << UNIT_FRAC_BITS;
    localparam longint SECTOR_SPAN = longint'(60) << HUE_FRAC_BITS;
    localparam longint FULL_TURN   = longint'(360) << HUE_FRAC_BITS;
    localparam longint FULL_SCALE  = 255;

    // Fraction within a sector, and the same range including the span itself.
    localparam int FRAC_W  = $clog2(SECTOR_SPAN);
    localparam int SPAN_W  = $clog2(SECTOR_SPAN + 1);

    // A channel weight lies in 0 .. UNIT_ONE * SECTOR_SPAN.
    localparam longint WEIGHT_MAX = UNIT_ONE * SECTOR_SPAN;
    localparam int     WEIGHT_W   = $clog2(WEIGHT_MAX + 1);
    localparam int     PROD_W     = UNIT_W + WEIGHT_W;

    // 255 / (ONE * ONE * SPAN) equals 17 / 2^SHIFT, since SPAN = 15 << (HUE_FRAC_BITS + 2).
    localparam int SCALED_W = PROD_W + 5;
    localparam int SHIFT    = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS + 2;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } t_sector;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic              hue_undefined;
        logic [UNIT_W-1:0] saturation;
        logic [UNIT_W-1:0] brightness;
    } t_hsv_word;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb_word;

endpackage

@@ rtl/hsv_to_rgb_converter.sv @@
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_ready    i_in_data: hue, hue_undefined, saturation, brightness
// out      out  o_out_valid / i_out_ready  o_out_data: red, green, blue
//
// Five register stages: sector split, saturation products, weight select,
// brightness multiply, scale and output register. One word enters per cycle while o_in_ready is high.
// Reset (synchronous, active low) clears only the stage valid bits.
// A stall at the output fills empty stages first; o_in_ready falls only when all
// five stages hold a word, and no word is dropped or repeated.
module hsv_to_rgb_converter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  hsv2rgb_pkg::t_hsv_word i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output hsv2rgb_pkg::t_rgb_word o_out_data
);

    localparam int UNIT_W   = hsv2rgb_pkg::UNIT_W;
    localparam int FRAC_W   = hsv2rgb_pkg::FRAC_W;
    localparam int SPAN_W   = hsv2rgb_pkg::SPAN_W;
    localparam int WEIGHT_W = hsv2rgb_pkg::WEIGHT_W;
    localparam int PROD_W   = hsv2rgb_pkg::PROD_W;
    localparam int SCALED_W = hsv2rgb_pkg::SCALED_W;
    localparam int CHAN_W   = hsv2rgb_pkg::CHAN_W;

    localparam logic [UNIT_W-1:0]   ONE_U    = UNIT_W'(hsv2rgb_pkg::UNIT_ONE);
    localparam logic [SPAN_W-1:0]   SPAN_S   = SPAN_W'(hsv2rgb_pkg::SECTOR_SPAN);
    localparam logic [WEIGHT_W-1:0] WMAX     = WEIGHT_W'(hsv2rgb_pkg::WEIGHT_MAX);
    localparam logic [SCALED_W-1:0] SCALE_MX = SCALED_W'(hsv2rgb_pkg::FULL_SCALE);

    function automatic logic [CHAN_W-1:0] scale_chan(input logic [PROD_W-1:0] p);
        logic [SCALED_W-1:0] x;
        logic [SCALED_W-1:0] hi;
        x  = (SCALED_W'(p) << 4) + SCALED_W'(p);
        hi = x >> hsv2rgb_pkg::SHIFT;
        return (hi > SCALE_MX) ? CHAN_W'(SCALE_MX) : CHAN_W'(hi);
    endfunction

    // Stage enables: a stage loads when it is empty or its word moves on.
    logic en1, en2, en3, en4, en5;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // Stage 1 registers.
    hsv2rgb_pkg::t_sector r_sec1, n_sec1;
    logic [FRAC_W-1:0]    r_frac1, n_frac1;
    logic [UNIT_W-1:0]    r_s1, n_s1;
    logic [UNIT_W-1:0]    r_val1, n_val1;
    logic                 r_blk1, n_blk1;

    // Stage 2 registers.
    hsv2rgb_pkg::t_sector r_sec2;
    logic [WEIGHT_W-1:0]  r_sf2, n_sf2;
    logic [WEIGHT_W-1:0]  r_sg2, n_sg2;
    logic [WEIGHT_W-1:0]  r_wp2, n_wp2;
    logic [UNIT_W-1:0]    r_val2;
    logic                 r_blk2;

    // Stage 3 registers.
    logic [WEIGHT_W-1:0]  r_wr3, r_wg3, r_wb3, n_wr3, n_wg3, n_wb3;
    logic [UNIT_W-1:0]    r_val3;
    logic                 r_blk3;

    // Stage 4 registers.
    logic [PROD_W-1:0]    r_pr4, r_pg4, r_pb4, n_pr4, n_pg4, n_pb4;
    logic                 r_blk4;

    // Stage 5 is the output register.
    hsv2rgb_pkg::t_rgb_word r_out5, n_out5;

    assign en5 = !r_v5 || i_out_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_ready  = en1;
    assign o_out_valid = r_v5;
    assign o_out_data  = r_out5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // Stage 1: clamp the units, set an undefined or out-of-range hue to zero and split it into sector and fraction.
    always_comb begin
        logic [31:0] hue_w;
        logic [31:0] base;
        logic [2:0]  sec;
        hue_w  = 32'(i_in_data.hue);
        n_s1   = (i_in_data.saturation > ONE_U) ? ONE_U : i_in_data.saturation;
        n_val1 = (i_in_data.brightness > ONE_U) ? ONE_U : i_in_data.brightness;
        // Zero saturation with a defined hue is black; with an undefined hue the
        // regular path gives grey, since every weight is then full.
        n_blk1 = (n_s1 == '0) && !i_in_data.hue_undefined;
        if (i_in_data.hue_undefined || (hue_w >= 32'(hsv2rgb_pkg::FULL_TURN))) begin
            hue_w = '0;
        end
        sec  = '0;
        base = '0;
        for (int k = 1; k < 6; k++) begin
            if (hue_w >= 32'(k * hsv2rgb_pkg::SECTOR_SPAN)) begin
                sec  = 3'(k);
                base = 32'(k * hsv2rgb_pkg::SECTOR_SPAN);
            end
        end
        n_sec1  = hsv2rgb_pkg::t_sector'(sec);
        n_frac1 = FRAC_W'(hue_w - base);
    end

    // Stage 2: saturation products for p, q and t.
    always_comb begin
        logic [SPAN_W-1:0] rest;
        rest  = SPAN_S - SPAN_W'(r_frac1);
        n_sf2 = WEIGHT_W'(WEIGHT_W'(r_s1) * WEIGHT_W'(r_frac1));
        n_sg2 = WEIGHT_W'(WEIGHT_W'(r_s1) * WEIGHT_W'(rest));
        n_wp2 = WEIGHT_W'(WEIGHT_W'(ONE_U - r_s1) * WEIGHT_W'(SPAN_S));
    end

    // Stage 3: finish q and t and route the weights by sector.
    always_comb begin
        logic [WEIGHT_W-1:0] wq;
        logic [WEIGHT_W-1:0] wt;
        wq = WMAX - r_sf2;
        wt = WMAX - r_sg2;
        case (r_sec2)
            hsv2rgb_pkg::SEC_RED_YELLOW: begin
                n_wr3 = WMAX;  n_wg3 = wt;    n_wb3 = r_wp2;
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
                n_wr3 = wq;    n_wg3 = WMAX;  n_wb3 = r_wp2;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN: begin
                n_wr3 = r_wp2; n_wg3 = WMAX;  n_wb3 = wt;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE: begin
                n_wr3 = r_wp2; n_wg3 = wq;    n_wb3 = WMAX;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
                n_wr3 = wt;    n_wg3 = r_wp2; n_wb3 = WMAX;
            end
            default: begin
                n_wr3 = WMAX;  n_wg3 = r_wp2; n_wb3 = wq;
            end
        endcase
    end

    // Stage 4: brightness times weight.
    always_comb begin
        n_pr4 = PROD_W'(PROD_W'(r_val3) * PROD_W'(r_wr3));
        n_pg4 = PROD_W'(PROD_W'(r_val3) * PROD_W'(r_wg3));
        n_pb4 = PROD_W'(PROD_W'(r_val3) * PROD_W'(r_wb3));
    end

    // Stage 5: scale to 0..255, truncating and clamping, or give zero for a black word.
    always_comb begin
        if (r_blk4) begin
            n_out5 = '0;
        end else begin
            n_out5.red   = scale_chan(r_pr4);
            n_out5.green = scale_chan(r_pg4);
            n_out5.blue  = scale_chan(r_pb4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_sec1  <= n_sec1;
            r_frac1 <= n_frac1;
            r_s1    <= n_s1;
            r_val1  <= n_val1;
            r_blk1  <= n_blk1;
        end
        if (en2) begin
            r_sec2 <= r_sec1;
            r_sf2  <= n_sf2;
            r_sg2  <= n_sg2;
            r_wp2  <= n_wp2;
            r_val2 <= r_val1;
            r_blk2 <= r_blk1;
        end
        if (en3) begin
            r_wr3  <= n_wr3;
            r_wg3  <= n_wg3;
            r_wb3  <= n_wb3;
            r_val3 <= r_val2;
            r_blk3 <= r_blk2;
        end
        if (en4) begin
            r_pr4  <= n_pr4;
            r_pg4  <= n_pg4;
            r_pb4  <= n_pb4;
            r_blk4 <= r_blk3;
        end
        if (en5) begin
            r_out5 <= n_out5;
        end
    end

    a_frac_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (longint'(r_frac1) < hsv2rgb_pkg::SECTOR_SPAN))
        else $error("sector fraction out of range");

    a_weights_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ((r_wr3 <= WMAX) && (r_wg3 <= WMAX) && (r_wb3 <= WMAX)))
        else $error("channel weight above full scale");

    a_black_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en5 && r_v4 && r_blk4) |=> (o_out_valid && (o_out_data == '0)))
        else $error("black word not zero at output");

    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5))
        else $error("input stalled with an empty stage");

endmodule

@@ tb/hsv_to_rgb_converter_tb.sv @@
module hsv_to_rgb_converter_tb;

    localparam int NUM_DIRECTED   = 25;
    localparam int NUM_RANDOM     = 1165;
    localparam int QUIET_TAIL     = 200;
    localparam int BACKLOG_WORDS  = 60;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CHAN_W         = hsv2rgb_pkg::CHAN_W;

    localparam longint unsigned ONE_U        = hsv2rgb_pkg::UNIT_ONE;
    localparam longint unsigned SPAN_U       = hsv2rgb_pkg::SECTOR_SPAN;
    localparam longint unsigned TURN_U       = hsv2rgb_pkg::FULL_TURN;
    localparam longint unsigned FULL_SCALE_U = hsv2rgb_pkg::FULL_SCALE;

    typedef struct packed {
        hsv2rgb_pkg::t_hsv_word hsv;
        logic                   has_rgb;
        hsv2rgb_pkg::t_rgb_word rgb;
    } t_directed_row;

    // Rows with has_rgb set carry a result that is plain from the inputs;
    // the others are predicted.
    localparam t_directed_row DIRECTED [NUM_DIRECTED] = '{
        '{'{16'd0,     1'b0, 13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{'{16'd0,     1'b0, 13'd0,    13'd4096}, 1'b1, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd0,     1'b1, 13'd0,    13'd4096}, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{'{16'd0,     1'b1, 13'd0,    13'd2048}, 1'b1, '{8'd127, 8'd127, 8'd127}},
        '{'{16'd0,     1'b1, 13'd0,    13'd0},    1'b1, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd0,     1'b1, 13'd0,    13'd8191}, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{'{16'd23040, 1'b0, 13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{'{16'd65535, 1'b0, 13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{'{16'd7680,  1'b1, 13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{'{16'd7680,  1'b0, 13'd4096, 13'd4096}, 1'b1, '{8'd0,   8'd255, 8'd0}},
        '{'{16'd15360, 1'b0, 13'd4096, 13'd4096}, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{'{16'd0,     1'b0, 13'd8191, 13'd8191}, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{'{16'd1000,  1'b0, 13'd4096, 13'd0},    1'b1, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd1920,  1'b0, 13'd4096, 13'd4096}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd5760,  1'b0, 13'd4096, 13'd4096}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd9600,  1'b0, 13'd2048, 13'd4096}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd13440, 1'b0, 13'd4096, 13'd3000}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd17280, 1'b0, 13'd1000, 13'd4096}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd21120, 1'b0, 13'd4096, 13'd4096}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd23039, 1'b0, 13'd4096, 13'd4096}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd3839,  1'b0, 13'd1,    13'd1},    1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd3840,  1'b0, 13'd8191, 13'd2000}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd65535, 1'b1, 13'd8191, 13'd8191}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd43690, 1'b0, 13'd5461, 13'd2730}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{16'd21845, 1'b0, 13'd2730, 13'd5461}, 1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    hsv2rgb_pkg::t_hsv_word i_in_data   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    hsv2rgb_pkg::t_rgb_word o_out_data;

    hsv2rgb_pkg::t_rgb_word rgb_expected [$];
    int        error_count   = 0;
    int        quiet_cycles  = 0;
    bit        idle_enable   = 1'b0;
    int        hold_request  = 0;

    hsv_to_rgb_converter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [CHAN_W-1:0] scale_chan(longint unsigned num);
        longint unsigned chan;
        chan = (num * FULL_SCALE_U) / (ONE_U * ONE_U * SPAN_U);
        if (chan > FULL_SCALE_U) chan = FULL_SCALE_U;
        return chan[CHAN_W-1:0];
    endfunction

    function automatic hsv2rgb_pkg::t_rgb_word predict_rgb(hsv2rgb_pkg::t_hsv_word w);
        longint unsigned        hue, s, v, frac, grey, vn, pn, qn, tn, rn, gn, bn;
        hsv2rgb_pkg::t_sector   sector;
        hsv2rgb_pkg::t_rgb_word rgb;
        s = 64'(w.saturation);
        v = 64'(w.brightness);
        if (s > ONE_U) s = ONE_U;
        if (v > ONE_U) v = ONE_U;
        // Without saturation the hue only decides between grey and black.
        if (s == 0) begin
            grey = w.hue_undefined ? (v * FULL_SCALE_U) / ONE_U : 0;
            if (grey > FULL_SCALE_U) grey = FULL_SCALE_U;
            rgb.red   = grey[CHAN_W-1:0];
            rgb.green = grey[CHAN_W-1:0];
            rgb.blue  = grey[CHAN_W-1:0];
            return rgb;
        end
        hue = 64'(w.hue);
        if (w.hue_undefined || hue >= TURN_U) hue = 0;
        sector = hsv2rgb_pkg::t_sector'(3'(hue / SPAN_U));
        frac   = hue % SPAN_U;
        // All channel weights share the denominator ONE * ONE * SPAN.
        vn = v * ONE_U * SPAN_U;
        pn = v * (ONE_U - s) * SPAN_U;
        qn = v * (ONE_U * SPAN_U - s * frac);
        tn = v * (ONE_U * SPAN_U - s * (SPAN_U - frac));
        case (sector)
            hsv2rgb_pkg::SEC_RED_YELLOW: begin
                rn = vn; gn = tn; bn = pn;
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
                rn = qn; gn = vn; bn = pn;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN: begin
                rn = pn; gn = vn; bn = tn;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE: begin
                rn = pn; gn = qn; bn = vn;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
                rn = tn; gn = pn; bn = vn;
            end
            default: begin
                rn = vn; gn = pn; bn = qn;
            end
        endcase
        rgb.red   = scale_chan(rn);
        rgb.green = scale_chan(gn);
        rgb.blue  = scale_chan(bn);
        return rgb;
    endfunction

    function automatic hsv2rgb_pkg::t_hsv_word random_hsv();
        hsv2rgb_pkg::t_hsv_word w;
        int                     kind;
        kind            = int'($urandom_range(0, 99));
        w.hue           = 16'($urandom_range(0, 32'(TURN_U - 1)));
        w.hue_undefined = ($urandom_range(0, 15) == 0);
        w.saturation    = 13'($urandom_range(1, 32'(ONE_U)));
        w.brightness    = 13'($urandom_range(0, 32'(ONE_U)));
        if (kind < 8) begin
            w.saturation = '0;
        end else if (kind < 16) begin
            w.hue = 16'($urandom_range(0, 65535));
        end else if (kind < 22) begin
            w.saturation = 13'($urandom_range(0, 8191));
        end else if (kind < 28) begin
            w.brightness = 13'($urandom_range(0, 8191));
        end else if (kind < 32) begin
            w.saturation = 13'(ONE_U);
            w.brightness = 13'(ONE_U);
        end else if (kind < 35) begin
            w.hue = 16'($urandom_range(0, 5) * 32'(SPAN_U));
        end
        return w;
    endfunction

    // Offers one word and returns in the time step at which it is taken.
    task automatic offer_word(input hsv2rgb_pkg::t_hsv_word w,
                              input hsv2rgb_pkg::t_rgb_word want);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        rgb_expected = {rgb_expected, want};
    endtask

    task automatic check_rgb(input hsv2rgb_pkg::t_rgb_word got);
        hsv2rgb_pkg::t_rgb_word want;
        if (rgb_expected.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected word: r %0d g %0d b %0d", got.red, got.green, got.blue);
        end else begin
            want = rgb_expected.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
                error_count++;
                if (error_count <= 10)
                    $display("wrong word: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                             want.red, want.green, want.blue, got.red, got.green, got.blue);
            end
        end
    endtask

    // Receiver: checks words and paces i_out_ready.
    initial begin
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_rgb(o_out_data);
            if (hold_request != hold_seen) begin
                hold_seen  = hold_request;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                stall_left = int'($urandom_range(0, 2));
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("hsv_to_rgb_converter: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        hsv2rgb_pkg::t_hsv_word w;
        repeat (4) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        idle_enable <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            offer_word(DIRECTED[i].hsv,
                       DIRECTED[i].has_rgb ? DIRECTED[i].rgb : predict_rgb(DIRECTED[i].hsv));
        end

        // Let the pipeline empty completely before going on.
        i_in_valid <= 1'b0;
        while (rgb_expected.size() != 0) @(posedge i_clk);

        // Back-to-back words against a long output stall fill every stage.
        idle_enable  <= 1'b0;
        hold_request <= hold_request + 1;
        for (int i = 0; i < BACKLOG_WORDS; i++) begin
            w = random_hsv();
            offer_word(w, predict_rgb(w));
        end

        idle_enable <= 1'b1;
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM - QUIET_TAIL) idle_enable <= 1'b0;
            w = random_hsv();
            offer_word(w, predict_rgb(w));
        end

        i_in_valid <= 1'b0;
        while (rgb_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && rgb_expected.size() == 0) begin
            $display("hsv_to_rgb_converter: match");
        end else begin
            $display("hsv_to_rgb_converter: mismatch");
        end
        $finish;
    end

endmodule
